@@ rtl/rsh_pkg.sv @@
package rsh_pkg;

  // Input field widths.
  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int LimW   = 31;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Internal widths, sized to the exact ranges of the intermediates.
  localparam int OcW    = CoordW + 1;   // origin - center
  localparam int AW     = 64;           // dir.dir, unsigned
  localparam int BW     = 67;           // oc.dir, signed
  localparam int CW     = 68;           // oc.oc - r^2, signed
  localparam int BAbsW  = BW - 1;
  localparam int CAbsW  = CW - 1;
  localparam int SplitW = 33;           // low chunk of the wide products
  localparam int PW     = 132;          // b^2 and a*|c|
  localparam int DW     = 134;          // discriminant, signed
  localparam int RootW  = DW / 2;       // floor(sqrt(D))
  localparam int RemW   = RootW + 3;    // square root remainder
  localparam int LimPW  = LimW + AW;    // limit * a
  localparam int NumW   = RootW + 2;    // -b -/+ s
  localparam int FracW  = 16;
  localparam int CmpW   = LimPW + 1;

  localparam logic [LimW-1:0] NearReset = LimW'(6554);
  localparam logic [LimW-1:0] FarReset  = LimW'(65536000);

  typedef enum logic [CfgIdxW-1:0] {
    CfgNear = 2'd0,
    CfgFar  = 2'd1
  } rsh_cfg_e;

  // Data that travels alongside the square root pipeline.
  typedef struct packed {
    logic signed [BW-1:0] b;
    logic [LimPW-1:0]     lo;
    logic [LimPW-1:0]     hi;
    logic                 dpos;
  } rsh_side_t;

endpackage

@@ rtl/ray_sphere_hit_test.sv @@
// Ray/sphere hit test. Each item carries a ray origin, a direction of any length and a
// sphere center in signed Q16.16 and an unsigned Q15.16 radius, and gives one hit flag:
// 1 when the discriminant is positive and a root of the intersection lies strictly between
// near_limit and far_limit. The discriminant is formed exactly and its floor square root
// is taken. The block takes one item every cycle while in_stall_o is low; a result passes
// through 75 register stages counting the input stage, most of them in the square root
// pipeline, which resolves one root bit per stage over 67 stages.
// Configuration writes are taken at any time (ready is always high) but must only be made
// while no item is in flight. When the output stalls, one result is held in a skid register
// and the whole pipeline then holds until that register drains.
module ray_sphere_hit_test
  import rsh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] origin_x_i,
  input  logic signed [CoordW-1:0] origin_y_i,
  input  logic signed [CoordW-1:0] origin_z_i,
  input  logic signed [CoordW-1:0] dir_x_i,
  input  logic signed [CoordW-1:0] dir_y_i,
  input  logic signed [CoordW-1:0] dir_z_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic [RadW-1:0]          radius_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_o
);

  logic [LimW-1:0] near_q, far_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NearReset;
      far_q  <= FarReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNear: near_q <= cfg_data_i[LimW-1:0];
        CfgFar:  far_q  <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable comes from the skid register alone.
  logic en;
  logic skid_v_q, skid_q, out_v_q, out_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // Stage 1: oc = origin - center.
  logic                    v1_q;
  logic signed [OcW-1:0]   oc_q [3];
  logic signed [CoordW-1:0] d_q [3];
  logic [RadW-1:0]         r_q;

  // Stage 2: elementary products.
  logic                    v2_q;
  logic signed [2*CoordW-1:0]    dd_q [3];
  logic signed [OcW+CoordW-1:0]  od_q [3];
  logic signed [2*OcW-1:0]       oo_q [3];
  logic [2*RadW-1:0]             rr_q;

  // Stage 3: a, b, c.
  logic                    v3_q;
  logic [AW-1:0]           a_q;
  logic signed [BW-1:0]    b3_q;
  logic [BAbsW-1:0]        babs_q;
  logic [CAbsW-1:0]        cabs_q;
  logic                    cneg3_q;

  // Stage 4: partial products.
  logic                    v4_q;
  logic signed [BW-1:0]    b4_q;
  logic                    cneg4_q;
  logic [2*SplitW-1:0]     bb_ll_q, bb_lh_q, bb_hh_q;
  logic [2*SplitW-1:0]     ac_ll_q;
  logic [CAbsW-1:0]        ac_lh_q;
  logic [AW-1:0]           ac_hl_q;
  logic [AW+1-1:0]         ac_hh_q;
  logic [LimW+32-1:0]      nl_q, nh_q, fl_q, fh_q;

  // Stage 5: b^2, a*|c|, limits times a.
  logic                    v5_q;
  logic signed [BW-1:0]    b5_q;
  logic                    cneg5_q;
  logic [PW-1:0]           bb_q, ac_q;
  logic [LimPW-1:0]        lo5_q, hi5_q;

  // Stage 6: discriminant.
  logic                    v6_q;
  logic [DW-1:0]           rad6_q;
  rsh_side_t               side6_q;

  // Square root pipeline output.
  logic                    vs;
  logic [RootW-1:0]        root;
  rsh_side_t               sides;

  // Stage 7: root numerators.
  logic                    v7_q;
  logic signed [NumW-1:0]  n1_q, n2_q;
  logic [LimPW-1:0]        lo7_q, hi7_q;
  logic                    dpos7_q;

  logic signed [BW-1:0]    b_sum;
  logic signed [CW-1:0]    c_sum;
  logic signed [DW-1:0]    disc;
  logic signed [BW-1:0]    b_neg;
  logic signed [CW-1:0]    c_neg;

  always_comb begin
    b_sum = BW'(od_q[0]) + BW'(od_q[1]) + BW'(od_q[2]);
    c_sum = CW'(oo_q[0]) + CW'(oo_q[1]) + CW'(oo_q[2]) - CW'(rr_q);
    b_neg = -b_sum;
    c_neg = -c_sum;
  end

  // b^2 - a*c, with the sign of c folded back in.
  always_comb begin
    disc = cneg5_q ? ($signed(DW'(bb_q)) + $signed(DW'(ac_q)))
                   : ($signed(DW'(bb_q)) - $signed(DW'(ac_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_q[0] <= OcW'(origin_x_i) - OcW'(center_x_i);
      oc_q[1] <= OcW'(origin_y_i) - OcW'(center_y_i);
      oc_q[2] <= OcW'(origin_z_i) - OcW'(center_z_i);
      d_q[0]  <= dir_x_i;
      d_q[1]  <= dir_y_i;
      d_q[2]  <= dir_z_i;
      r_q     <= radius_i;

      for (int k = 0; k < 3; k++) begin
        dd_q[k] <= d_q[k] * d_q[k];
        od_q[k] <= oc_q[k] * d_q[k];
        oo_q[k] <= oc_q[k] * oc_q[k];
      end
      rr_q <= r_q * r_q;

      a_q     <= AW'(dd_q[0]) + AW'(dd_q[1]) + AW'(dd_q[2]);
      b3_q    <= b_sum;
      babs_q  <= b_sum[BW-1] ? b_neg[BAbsW-1:0] : b_sum[BAbsW-1:0];
      cabs_q  <= c_sum[CW-1] ? c_neg[CAbsW-1:0] : c_sum[CAbsW-1:0];
      cneg3_q <= c_sum[CW-1];

      b4_q    <= b3_q;
      cneg4_q <= cneg3_q;
      bb_ll_q <= babs_q[SplitW-1:0] * babs_q[SplitW-1:0];
      bb_lh_q <= babs_q[SplitW-1:0] * babs_q[BAbsW-1:SplitW];
      bb_hh_q <= babs_q[BAbsW-1:SplitW] * babs_q[BAbsW-1:SplitW];
      ac_ll_q <= a_q[SplitW-1:0] * cabs_q[SplitW-1:0];
      ac_lh_q <= a_q[SplitW-1:0] * cabs_q[CAbsW-1:SplitW];
      ac_hl_q <= a_q[AW-1:SplitW] * cabs_q[SplitW-1:0];
      ac_hh_q <= a_q[AW-1:SplitW] * cabs_q[CAbsW-1:SplitW];
      nl_q    <= near_q * a_q[31:0];
      nh_q    <= near_q * a_q[AW-1:32];
      fl_q    <= far_q * a_q[31:0];
      fh_q    <= far_q * a_q[AW-1:32];

      b5_q    <= b4_q;
      cneg5_q <= cneg4_q;
      bb_q    <= (PW'(bb_hh_q) << (2*SplitW)) + (PW'(bb_lh_q) << (SplitW+1))
                 + PW'(bb_ll_q);
      ac_q    <= (PW'(ac_hh_q) << (2*SplitW))
                 + ((PW'(ac_lh_q) + PW'(ac_hl_q)) << SplitW) + PW'(ac_ll_q);
      lo5_q   <= (LimPW'(nh_q) << 32) + LimPW'(nl_q);
      hi5_q   <= (LimPW'(fh_q) << 32) + LimPW'(fl_q);

      rad6_q       <= disc;
      side6_q.b    <= b5_q;
      side6_q.lo   <= lo5_q;
      side6_q.hi   <= hi5_q;
      side6_q.dpos <= !disc[DW-1] && (disc != '0);

      n1_q    <= -NumW'(sides.b) - $signed(NumW'(root));
      n2_q    <= -NumW'(sides.b) + $signed(NumW'(root));
      lo7_q   <= sides.lo;
      hi7_q   <= sides.hi;
      dpos7_q <= sides.dpos;
    end
  end

  rsh_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rad_i   (rad6_q),
    .side_i  (side6_q),
    .valid_o (vs),
    .root_o  (root),
    .side_o  (sides)
  );

  // Window test: near*a < n*2^16 < far*a for either root, with a positive discriminant.
  logic signed [CmpW-1:0] sc1, sc2, lo_s, hi_s;
  logic                   hit_d;

  always_comb begin
    sc1   = {{(CmpW-NumW-FracW){n1_q[NumW-1]}}, n1_q, {FracW{1'b0}}};
    sc2   = {{(CmpW-NumW-FracW){n2_q[NumW-1]}}, n2_q, {FracW{1'b0}}};
    lo_s  = {1'b0, lo7_q};
    hi_s  = {1'b0, hi7_q};
    hit_d = dpos7_q && (((sc1 > lo_s) && (sc1 < hi_s)) || ((sc2 > lo_s) && (sc2 < hi_s)));
  end

  // Output register with one skid entry behind it.
  logic arr_v;
  assign arr_v = en && v7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= arr_v;
      end
    end else if (arr_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : hit_d;
    end else if (arr_v) begin
      skid_q <= hit_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = out_q;

endmodule

@@ rtl/rsh_isqrt.sv @@
module rsh_isqrt
  import rsh_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DW-1:0]   rad_i,
  input  rsh_side_t       side_i,
  output logic            valid_o,
  output logic [RootW-1:0] root_o,
  output rsh_side_t       side_o
);

  // One result bit per stage, restoring method, most significant bit first.
  logic [RemW-1:0]  rem_in  [RootW];
  logic [RootW-1:0] root_in [RootW];
  logic [DW-1:0]    rad_in  [RootW];
  rsh_side_t        side_in [RootW];
  logic             v_in    [RootW];

  logic [RemW-1:0]  rem_d  [RootW];
  logic [RootW-1:0] root_d [RootW];
  logic [DW-1:0]    rad_d  [RootW];

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [DW-1:0]    rad_q  [RootW];
  rsh_side_t        side_q [RootW];
  logic             v_q    [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign rad_in[k]  = rad_i;
      assign side_in[k] = side_i;
      assign v_in[k]    = valid_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign rad_in[k]  = rad_q[k-1];
      assign side_in[k] = side_q[k-1];
      assign v_in[k]    = v_q[k-1];
    end

    assign cur   = {rem_in[k][RemW-3:0], rad_in[k][DW-1:DW-2]};
    assign trial = {1'b0, root_in[k], 2'b01};
    assign ge    = (cur >= trial);

    always_comb begin
      rem_d[k]  = ge ? (cur - trial) : cur;
      root_d[k] = {root_in[k][RootW-2:0], ge};
      rad_d[k]  = {rad_in[k][DW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RootW; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < RootW; k++) v_q[k] <= v_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RootW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

@@ verif/tb_ray_sphere_hit_test.sv @@
`timescale 1ns / 1ps

module tb_ray_sphere_hit_test;
  import rsh_pkg::*;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [CoordW-1:0] ox, oy, oz;
    logic signed [CoordW-1:0] dx, dy, dz;
    logic signed [CoordW-1:0] cx, cy, cz;
    logic [RadW-1:0]          rad;
  } ray_t;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd2;
  localparam int StuckLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int FlushCycles = 90;
  localparam int Unit = 65536;
  localparam int ExpDepth = 1024;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [CoordW-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [CoordW-1:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [RadW-1:0]          radius_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     hit_o;

  ray_sphere_hit_test dut (.*);

  always #5 clk_i = ~clk_i;

  logic [LimW-1:0] near_lim = NearReset;
  logic [LimW-1:0] far_lim  = FarReset;
  // Expected results in order, written at input accept and read at output accept.
  logic exp_mem [ExpDepth];
  int   exp_wr = 0;
  int   exp_rd = 0;
  int   err_count = 0;
  int   stuck_cycles = 0;
  bit   src_gaps = 1'b1;
  bit   sink_gaps = 1'b1;
  bit   hold_req = 1'b0;

  // Exact hit decision in wide two's complement arithmetic.
  function automatic logic predict_hit(ray_t r, logic [LimW-1:0] nl, logic [LimW-1:0] fl);
    wide_t ocx, ocy, ocz, vx, vy, vz, a, b, c, disc, s, cand, lo, hi, n1, n2;
    if (r.dx == 0 && r.dy == 0 && r.dz == 0) return 1'b0;
    ocx = wide_t'(r.ox) - wide_t'(r.cx);
    ocy = wide_t'(r.oy) - wide_t'(r.cy);
    ocz = wide_t'(r.oz) - wide_t'(r.cz);
    vx = wide_t'(r.dx);
    vy = wide_t'(r.dy);
    vz = wide_t'(r.dz);
    a = vx * vx + vy * vy + vz * vz;
    b = ocx * vx + ocy * vy + ocz * vz;
    c = ocx * ocx + ocy * ocy + ocz * ocz - wide_t'(r.rad) * wide_t'(r.rad);
    disc = b * b - a * c;
    if (disc <= 0) return 1'b0;
    s = '0;
    for (int k = 67; k >= 0; k--) begin
      cand = s | (wide_t'(1) << k);
      if (cand * cand <= disc) s = cand;
    end
    lo = wide_t'(nl) * a;
    hi = wide_t'(fl) * a;
    n1 = (-b - s) * wide_t'(Unit);
    n2 = (-b + s) * wide_t'(Unit);
    return (n1 > lo && n1 < hi) || (n2 > lo && n2 < hi);
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, hit_o);
        err_count++;
      end else begin
        logic want;
        want = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (hit_o !== want) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, hit_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles where no item or register write moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold when requested.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_ray(ray_t r);
    int n;
    @(negedge clk_i);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    origin_x_i = r.ox; origin_y_i = r.oy; origin_z_i = r.oz;
    dir_x_i = r.dx; dir_y_i = r.dy; dir_z_i = r.dz;
    center_x_i = r.cx; center_y_i = r.cy; center_z_i = r.cz;
    radius_i = r.rad;
    do @(posedge clk_i); while (in_stall_o);
    exp_mem[exp_wr % ExpDepth] = predict_hit(r, near_lim, far_lim);
    exp_wr++;
  endtask

  // Waits for every outstanding result and lets the pipeline empty.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (exp_wr == exp_rd);
    repeat (FlushCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgNear) near_lim = data[LimW-1:0];
    else if (idx == CfgFar) far_lim = data[LimW-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic int rnd_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int cx, int cy, int cz, int rad);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    r.cx = cx; r.cy = cy; r.cz = cz;
    r.rad = rad[RadW-1:0];
    return r;
  endfunction

  // Most rays are aimed near a sphere; one in six is raw full-range noise.
  function automatic ray_t random_ray();
    ray_t r;
    int ox, oy, oz, cx, cy, cz, sh;
    if ($urandom_range(0, 5) == 0) begin
      r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
    end else begin
      ox = rnd_span(300 * Unit); oy = rnd_span(300 * Unit); oz = rnd_span(300 * Unit);
      cx = rnd_span(300 * Unit); cy = rnd_span(300 * Unit); cz = rnd_span(300 * Unit);
      sh = $urandom_range(0, 8);
      r = make_ray(ox, oy, oz,
                   ((cx - ox) >>> sh) + rnd_span(4 * Unit),
                   ((cy - oy) >>> sh) + rnd_span(4 * Unit),
                   ((cz - oz) >>> sh) + rnd_span(4 * Unit),
                   cx, cy, cz, $urandom_range(0, 60 * Unit));
      // Occasionally flip the ray so the sphere lies behind the origin.
      if ($urandom_range(0, 7) == 0) begin
        r.dx = -r.dx; r.dy = -r.dy; r.dz = -r.dz;
      end
    end
    return r;
  endfunction

  task automatic test_directed();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // Zero direction never hits, even from inside a sphere.
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 5 * Unit));
    send_ray(make_ray(0, 0, 0, Unit, 0, 0, 10 * Unit, 0, 0, Unit));
    // Tangent ray: the discriminant is exactly zero.
    send_ray(make_ray(0, 0, 0, Unit, 0, 0, 10 * Unit, 5 * Unit, 0, 5 * Unit));
    send_ray(make_ray(0, 0, 0, Unit, 0, 0, 10 * Unit, 5 * Unit, 0, 5 * Unit + 1));
    send_ray(make_ray(0, 0, 0, 0, Unit, 0, 10 * Unit, 0, 0, Unit));
    // Origin inside the sphere: only the far root is in front.
    send_ray(make_ray(0, 0, 0, 0, 0, Unit, 0, 0, 0, 3 * Unit));
    // Sphere behind the ray.
    send_ray(make_ray(0, 0, 0, -Unit, 0, 0, 10 * Unit, 0, 0, Unit));
    // Sphere beyond the far limit, and one whose root lies exactly on the near limit.
    send_ray(make_ray(0, 0, 0, Unit, 0, 0, 2000 * Unit, 0, 0, Unit));
    send_ray(make_ray(0, 0, 0, Unit, 0, 0, 0, 0, 0, 6554));
    send_ray(make_ray(0, 0, 0, 3, -7, 1, 20 * Unit, -30 * Unit, 8 * Unit, 2 * Unit));
    send_ray(make_ray(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_ray(make_ray(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0));
    send_ray(make_ray(mn, mn, mn, mx, mx, mx, mx, mx, mx, mx));
    send_ray(make_ray(mx, mn, mx, mn, mx, mn, mn, mx, mn, mx));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, mx));
    send_ray(make_ray(0, 0, 0, 1, 0, 0, mx, 0, 0, mx));
    drain();
  endtask

  task automatic test_limits();
    logic [CfgDataW-1:0] lims[6][2];
    lims = '{'{32'h0, 32'h7fffffff}, '{32'h7fffffff, 32'h0},
             '{32'h0008_0000, 32'h0008_0000}, '{32'hffffffff, 32'h8000_0001},
             '{32'h0, 32'h0040_0000}, '{32'h0, 32'h0000_0001}};
    foreach (lims[i]) begin
      write_limit(CfgNear, lims[i][0]);
      write_limit(CfgFar, lims[i][1]);
      // Writes to an unused index must change nothing.
      write_limit(CfgSpare, $urandom);
      write_limit(CfgUnused, $urandom);
      repeat (20) send_ray(random_ray());
      drain();
    end
    write_limit(CfgNear, 32'(NearReset));
    write_limit(CfgFar, 32'(FarReset));
  endtask

  task automatic test_random();
    repeat (100) send_ray(random_ray());
    drain();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_hold_off();
    hold_req = 1'b1;
    repeat (100) send_ray(random_ray());
    drain();
  endtask

  task automatic test_streaming();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    repeat (60) send_ray(random_ray());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_limits();
    test_random();
    test_hold_off();
    test_streaming();
    if (err_count == 0 && exp_wr == exp_rd) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rsh_pkg.sv
rtl/rsh_isqrt.sv
rtl/ray_sphere_hit_test.sv
verif/tb_ray_sphere_hit_test.sv
